// ----- rtl/core/ray_cell_traversal_core_defines.svh -----
// assertion macros for the ray cell traversal core
// used by the rtl/core modules that carry concurrent checks
`ifndef RAY_CELL_TRAVERSAL_CORE_DEFINES_SVH
`define RAY_CELL_TRAVERSAL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RCT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rct assertion failed");
`define RCT_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("rct assertion failed");
`else
`define RCT_ASSERT(lbl, clk, rst, prop)
`define RCT_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// ----- rtl/core/rct_pkg.sv -----
// shared types and constants of the ray cell traversal core
// no dependencies
package rct_pkg;
   localparam int FINE_W     = 22;
   localparam int CFG_W      = 11;
   localparam int OUT_CELL_W = 12;
   localparam int REM_W      = 11;
   localparam int MUL_A_W    = 12;
   localparam int MUL_B_W    = 16;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W      = 32;
   localparam int DIV_LANES  = 4;
   localparam logic [CFG_W-1:0] SCALE_RESET = 11'd1000;
   localparam logic [CFG_W-1:0] SCALE_MAX   = 11'd1024;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_DIV, OP_CHECK, OP_MDEN, OP_MINIT, OP_MT, OP_MINC,
      OP_MLAST, OP_FIRST, OP_CHK, OP_INC, OP_LAST, OP_TAIL, OP_COL, OP_FLUSH,
      OP_ERR
   } rct_op_type;

   typedef struct packed {
      rct_op_type op;
      logic       go;
   } rct_cmd_type;

   typedef struct packed {
      logic div_done;
      logic span_err;
      logic same_col;
      logic acc_neg;
      logic acc_zero;
      logic x_last;
      logic y_done;
   } rct_sts_type;
endpackage

// ----- rtl/core/rct_req_if.sv -----
// ray request channel: valid/ready handshake with the two endpoints
// depends on rct_pkg
interface rct_req_if;
   import rct_pkg::*;
   logic              valid;
   logic              ready;
   logic [FINE_W-1:0] start_x_fine;
   logic [FINE_W-1:0] start_y_fine;
   logic [FINE_W-1:0] stop_x_fine;
   logic [FINE_W-1:0] stop_y_fine;
   modport source (output valid, start_x_fine, start_y_fine, stop_x_fine, stop_y_fine,
                   input ready);
   modport sink (input valid, start_x_fine, start_y_fine, stop_x_fine, stop_y_fine,
                 output ready);
endinterface

// ----- rtl/core/rct_rsp_if.sv -----
// cell result channel: valid/ready handshake with one touched cell
// depends on rct_pkg
interface rct_rsp_if;
   import rct_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [OUT_CELL_W-1:0] cell_x;
   logic [OUT_CELL_W-1:0] cell_y;
   logic                  is_last;
   logic                  span_error;
   modport source (output valid, cell_x, cell_y, is_last, span_error, input ready);
   modport sink (input valid, cell_x, cell_y, is_last, span_error, output ready);
endinterface

// ----- rtl/core/rct_div.sv -----
// four-lane restoring divider, one quotient bit per lane per cycle
// depends on rct_pkg
module rct_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [rct_pkg::FINE_W-1:0]         dividend [rct_pkg::DIV_LANES],
   input  logic [rct_pkg::CFG_W-1:0]          divisor,
   output logic [rct_pkg::FINE_W-1:0]         quot [rct_pkg::DIV_LANES],
   output logic [rct_pkg::REM_W-1:0]          rem [rct_pkg::DIV_LANES],
   output logic                               done
);
   import rct_pkg::*;
   localparam int CNT_W = $clog2(FINE_W + 1);

   logic [FINE_W-1:0] dvd_ff [DIV_LANES];
   logic [FINE_W-1:0] dvd_in [DIV_LANES];
   logic [REM_W-1:0]  rem_ff [DIV_LANES];
   logic [REM_W-1:0]  rem_in [DIV_LANES];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [REM_W:0]    trial [DIV_LANES];
   logic              fits  [DIV_LANES];

   always_comb begin
      for (int i = 0; i < DIV_LANES; i++) begin
         trial[i]  = {rem_ff[i], dvd_ff[i][FINE_W-1]};
         fits[i]   = trial[i] >= {1'b0, divisor};
         dvd_in[i] = dvd_ff[i];
         rem_in[i] = rem_ff[i];
         if (start) begin
            dvd_in[i] = dividend[i];
            rem_in[i] = '0;
         end else if (cnt_ff != '0) begin
            dvd_in[i] = {dvd_ff[i][FINE_W-2:0], fits[i]};
            rem_in[i] = fits[i] ? REM_W'(trial[i] - {1'b0, divisor}) : trial[i][REM_W-1:0];
         end
      end
      if (start) begin
         cnt_in = CNT_W'(FINE_W);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign quot = dvd_ff;
   assign rem  = rem_ff;
   assign done = (cnt_ff == '0);
endmodule

// ----- rtl/core/rct_datapath.sv -----
// traversal datapath: endpoint registers, divider, shared multiplier,
// accumulator and cell cursor; depends on rct_pkg and rct_div
module rct_datapath #(
   parameter int GRID_CELLS     = 4096,
   parameter int MAX_SPAN_CELLS = 31,
   parameter int CELL_W         = 13
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rct_pkg::rct_cmd_type        cmd,
   input  logic                        csr_we,
   input  logic [rct_pkg::CFG_W-1:0]   csr_wdata,
   input  logic [rct_pkg::FINE_W-1:0]  start_x_fine,
   input  logic [rct_pkg::FINE_W-1:0]  start_y_fine,
   input  logic [rct_pkg::FINE_W-1:0]  stop_x_fine,
   input  logic [rct_pkg::FINE_W-1:0]  stop_y_fine,
   output rct_pkg::rct_sts_type        sts,
   output logic                        cand_valid,
   output logic [CELL_W-1:0]           cand_x,
   output logic [CELL_W-1:0]           cand_y
);
   import rct_pkg::*;

   logic [CFG_W-1:0]  scale_ff, scale;
   logic [FINE_W-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic [FINE_W-1:0] dvd [DIV_LANES];
   logic [FINE_W-1:0] quot [DIV_LANES];
   logic [REM_W-1:0]  rem [DIV_LANES];
   logic              swap, div_done;

   logic signed [ACC_W-1:0] den_ff, init_ff, t_ff, inc_ff, last_ff, acc_ff, acc_in;
   logic [CELL_W-1:0] curx_ff, curx_in, cury_ff, cury_in, yhi_ff, yhi_in, cex_ff, cex_in;
   logic [CELL_W-1:0] ynext, ylo;

   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] prod;
   logic signed [ACC_W-1:0] prod_s;

   logic [MUL_B_W-1:0] dx, absdy;
   logic               up;
   logic [MUL_A_W-1:0] s2, fp, lp, ip;
   logic [FINE_W-1:0]  spx, spy, qylo, qyhi;
   logic               over_grid;

   always_comb begin
      priority if (scale_ff == '0) begin
         scale = CFG_W'(1);
      end else if (scale_ff > SCALE_MAX) begin
         scale = SCALE_MAX;
      end else begin
         scale = scale_ff;
      end
   end

   // order the endpoints by x before dividing
   assign swap   = start_x_fine > stop_x_fine;
   assign dvd[0] = swap ? stop_x_fine  : start_x_fine;
   assign dvd[1] = swap ? stop_y_fine  : start_y_fine;
   assign dvd[2] = swap ? start_x_fine : stop_x_fine;
   assign dvd[3] = swap ? start_y_fine : stop_y_fine;

   rct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.go && cmd.op == OP_LOAD),
      .dividend (dvd),
      .divisor  (scale),
      .quot     (quot),
      .rem      (rem),
      .done     (div_done)
   );

   assign dx    = MUL_B_W'(x1_ff - x0_ff);
   assign up    = y1_ff > y0_ff;
   assign absdy = MUL_B_W'(up ? y1_ff - y0_ff : y0_ff - y1_ff);
   assign s2    = {scale, 1'b0};
   assign fp    = s2 - {rem[0], 1'b0} - MUL_A_W'(1);
   assign lp    = {rem[2], 1'b1};
   assign ip    = {rem[1], 1'b1};

   assign spx       = quot[2] - quot[0];
   assign spy       = (quot[1] > quot[3]) ? quot[1] - quot[3] : quot[3] - quot[1];
   assign qylo      = (quot[1] < quot[3]) ? quot[1] : quot[3];
   assign qyhi      = (quot[1] < quot[3]) ? quot[3] : quot[1];
   assign over_grid = ({1'b0, quot[0]} >= (FINE_W+1)'(GRID_CELLS))
                    || ({1'b0, quot[1]} >= (FINE_W+1)'(GRID_CELLS))
                    || ({1'b0, quot[2]} >= (FINE_W+1)'(GRID_CELLS))
                    || ({1'b0, quot[3]} >= (FINE_W+1)'(GRID_CELLS));

   // one shared multiplier, operands chosen by the setup step
   always_comb begin
      unique case (cmd.op)
         OP_MDEN:  begin mul_a = {1'b0, scale}; mul_b = dx;    end
         OP_MINIT: begin mul_a = ip;            mul_b = dx;    end
         OP_MT:    begin mul_a = fp;            mul_b = absdy; end
         OP_MINC:  begin mul_a = s2;            mul_b = absdy; end
         OP_MLAST: begin mul_a = lp;            mul_b = absdy; end
         default:  begin mul_a = '0;            mul_b = '0;    end
      endcase
   end
   assign prod   = mul_a * mul_b;
   assign prod_s = ACC_W'(prod);

   assign ynext = up ? cury_ff + 1'b1 : cury_ff - 1'b1;
   assign ylo   = CELL_W'(qylo);

   always_comb begin
      acc_in  = acc_ff;
      curx_in = curx_ff;
      cury_in = cury_ff;
      yhi_in  = yhi_ff;
      cex_in  = cex_ff;
      cand_valid = 1'b0;
      cand_x  = curx_ff;
      cand_y  = cury_ff;
      unique case (cmd.op)
         OP_CHECK: begin
            curx_in = CELL_W'(quot[0]);
            cury_in = (quot[0] == quot[2]) ? ylo : CELL_W'(quot[1]);
            yhi_in  = CELL_W'(qyhi);
            cex_in  = CELL_W'(quot[2]);
         end
         OP_MINC: begin
            acc_in = up ? den_ff - init_ff - t_ff : init_ff - t_ff;
         end
         OP_FIRST: begin
            cand_valid = 1'b1;
         end
         OP_CHK, OP_TAIL: begin
            if (acc_ff < 0) begin
               cand_valid = 1'b1;
               cand_y  = ynext;
               acc_in  = acc_ff + den_ff;
               cury_in = ynext;
            end else if (cmd.op == OP_CHK) begin
               curx_in = curx_ff + 1'b1;
               if (acc_ff == 0) begin
                  acc_in  = acc_ff + den_ff;
                  cury_in = ynext;
               end
            end
         end
         OP_INC: begin
            cand_valid = 1'b1;
            acc_in = acc_ff + inc_ff;
         end
         OP_LAST: begin
            cand_valid = 1'b1;
            acc_in = acc_ff + last_ff;
         end
         OP_COL: begin
            cand_valid = 1'b1;
            cury_in = cury_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_we) begin
         scale_ff <= csr_wdata;
      end
      if (cmd.go) begin
         if (cmd.op == OP_LOAD) begin
            x0_ff <= dvd[0];
            y0_ff <= dvd[1];
            x1_ff <= dvd[2];
            y1_ff <= dvd[3];
         end
         if (cmd.op == OP_MDEN)  den_ff  <= prod_s <<< 1;
         if (cmd.op == OP_MINIT) init_ff <= prod_s;
         if (cmd.op == OP_MT)    t_ff    <= prod_s;
         if (cmd.op == OP_MINC)  inc_ff  <= -prod_s;
         if (cmd.op == OP_MLAST) last_ff <= -prod_s;
         acc_ff  <= acc_in;
         curx_ff <= curx_in;
         cury_ff <= cury_in;
         yhi_ff  <= yhi_in;
         cex_ff  <= cex_in;
      end
   end

   assign sts.div_done = div_done;
   assign sts.span_err = (spx > FINE_W'(MAX_SPAN_CELLS)) || (spy > FINE_W'(MAX_SPAN_CELLS))
                       || over_grid;
   assign sts.same_col = quot[0] == quot[2];
   assign sts.acc_neg  = acc_ff < 0;
   assign sts.acc_zero = acc_ff == 0;
   assign sts.x_last   = ({1'b0, curx_ff} + 1'b1) >= {1'b0, cex_ff};
   assign sts.y_done   = cury_ff == yhi_ff;
endmodule

// ----- rtl/core/rct_emit.sv -----
// result stage: drops repeated cells, holds one cell back to mark the last
// one, and drives the result channel; depends on rct_pkg, rct_rsp_if and the defines header
`include "ray_cell_traversal_core_defines.svh"
module rct_emit #(
   parameter int CELL_W = 13
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rct_pkg::rct_cmd_type cmd,
   input  logic                 cand_valid,
   input  logic [CELL_W-1:0]    cand_x,
   input  logic [CELL_W-1:0]    cand_y,
   output logic                 stall,
   rct_rsp_if.source            rsp
);
   import rct_pkg::*;

   logic                  pend_valid_ff, pend_valid_in;
   logic [CELL_W-1:0]     pend_x_ff, pend_y_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [OUT_CELL_W-1:0] out_x_ff, out_y_ff;
   logic                  out_last_ff, out_err_ff;
   logic                  out_free, push, flush, err, load;

   assign flush    = cmd.op == OP_FLUSH;
   assign err      = cmd.op == OP_ERR;
   assign out_free = !out_valid_ff || rsp.ready;
   assign push     = cand_valid && (!pend_valid_ff || cand_x != pend_x_ff
                                    || cand_y != pend_y_ff);
   assign stall    = ((push && pend_valid_ff) || flush || err) && !out_free;
   assign load     = !stall && ((push && pend_valid_ff) || flush || err);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (!stall && push) begin
         pend_valid_in = 1'b1;
      end else if (!stall && flush) begin
         pend_valid_in = 1'b0;
      end
      out_valid_in = (out_valid_ff && !rsp.ready) || load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      if (!stall && push) begin
         pend_x_ff <= cand_x;
         pend_y_ff <= cand_y;
      end
      if (load) begin
         out_x_ff    <= err ? '0 : OUT_CELL_W'(FINE_W'(pend_x_ff));
         out_y_ff    <= err ? '0 : OUT_CELL_W'(FINE_W'(pend_y_ff));
         out_last_ff <= flush || err;
         out_err_ff  <= err;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.cell_x     = out_x_ff;
   assign rsp.cell_y     = out_y_ff;
   assign rsp.is_last    = out_last_ff;
   assign rsp.span_error = out_err_ff;

   `RCT_ASSERT(a_flush_has_cell, clock, reset, !flush || pend_valid_ff)
   `RCT_ASSERT(a_err_no_cell, clock, reset, !err || !pend_valid_ff)
   `RCT_ASSERT_NEXT(a_flush_clears, clock, reset, flush && !stall, !pend_valid_ff)
endmodule

// ----- rtl/core/rct_ctrl.sv -----
// traversal controller: one-hot state machine that sequences divide,
// setup multiplies and the cell walk; depends on rct_pkg
module rct_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rct_pkg::rct_sts_type sts,
   input  logic                 stall,
   output rct_pkg::rct_cmd_type cmd
);
   import rct_pkg::*;

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001, S_DIV   = 16'h0002, S_CHECK = 16'h0004, S_MDEN  = 16'h0008,
      S_MINIT = 16'h0010, S_MT    = 16'h0020, S_MINC  = 16'h0040, S_MLAST = 16'h0080,
      S_FIRST = 16'h0100, S_CHK   = 16'h0200, S_INC   = 16'h0400, S_LAST  = 16'h0800,
      S_TAIL  = 16'h1000, S_COL   = 16'h2000, S_FLUSH = 16'h4000, S_ERR   = 16'h8000
   } rct_state_type;

   rct_state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd.go   = !stall;
      unique case (state_ff)
         S_IDLE: begin
            cmd.op = OP_LOAD;
            cmd.go = req_valid;
            if (req_valid) state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            if (sts.div_done) state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.op = OP_CHECK;
            priority if (sts.span_err) state_in = S_ERR;
            else if (sts.same_col) state_in = S_COL;
            else state_in = S_MDEN;
         end
         S_MDEN:  begin cmd.op = OP_MDEN;  state_in = S_MINIT; end
         S_MINIT: begin cmd.op = OP_MINIT; state_in = S_MT;    end
         S_MT:    begin cmd.op = OP_MT;    state_in = S_MINC;  end
         S_MINC:  begin cmd.op = OP_MINC;  state_in = S_MLAST; end
         S_MLAST: begin cmd.op = OP_MLAST; state_in = S_FIRST; end
         S_FIRST: begin
            cmd.op = OP_FIRST;
            if (!stall) state_in = S_CHK;
         end
         S_CHK: begin
            cmd.op = OP_CHK;
            // leaving the column once the accumulator is non-negative
            if (!sts.acc_neg) state_in = sts.x_last ? S_LAST : S_INC;
         end
         S_INC: begin
            cmd.op = OP_INC;
            if (!stall) state_in = S_CHK;
         end
         S_LAST: begin
            cmd.op = OP_LAST;
            if (!stall) state_in = S_TAIL;
         end
         S_TAIL: begin
            cmd.op = OP_TAIL;
            if (!sts.acc_neg) state_in = S_FLUSH;
         end
         S_COL: begin
            cmd.op = OP_COL;
            if (!stall && sts.y_done) state_in = S_FLUSH;
         end
         S_FLUSH: begin
            cmd.op = OP_FLUSH;
            if (!stall) state_in = S_IDLE;
         end
         S_ERR: begin
            cmd.op = OP_ERR;
            if (!stall) state_in = S_IDLE;
         end
         default: begin
            cmd.op   = OP_NONE;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- rtl/core/ray_cell_traversal_core.sv -----
// ray cell traversal core: lists every grid cell a ray segment touches
// req_chan takes one ray as two endpoints in sub-cell units; rsp_chan
// returns the touched cells in walk order, one item per cell, with
// is_last set on the final cell. A ray whose endpoint cells are more than
// MAX_SPAN_CELLS apart, or that leaves the grid, returns a single item
// with span_error and is_last set and cell 0,0.
// csr_we/csr_wdata write the sub-cell units per cell (0 acts as 1, above
// 1024 as 1024); write it only while no ray is in flight.
// One ray at a time: req_chan.ready is high only between rays. Each ray
// passes an accept step, the four-lane restoring divider, a check step
// and, off a single column, the setup multiplies on the shared multiplier;
// then the walk visits each touched cell and column crossing, closes the
// tail and releases the held last cell.
// The result register holds its item while rsp_chan.ready is low and the
// walk pauses; nothing is dropped. Synchronous reset returns to idle,
// clears the result channel and sets the scale back to 1000.
module ray_cell_traversal_core #(
   parameter int GRID_CELLS     = 4096,
   parameter int MAX_SPAN_CELLS = 31
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [rct_pkg::CFG_W-1:0]  csr_wdata,
   rct_req_if.sink                    req_chan,
   rct_rsp_if.source                  rsp_chan
);
   import rct_pkg::*;
   localparam int CELL_W = $clog2(GRID_CELLS) + 1;

   rct_cmd_type       cmd;
   rct_sts_type       sts;
   logic              stall, cand_valid;
   logic [CELL_W-1:0] cand_x, cand_y;

   rct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .stall     (stall),
      .cmd       (cmd)
   );

   rct_datapath #(
      .GRID_CELLS     (GRID_CELLS),
      .MAX_SPAN_CELLS (MAX_SPAN_CELLS),
      .CELL_W         (CELL_W)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .start_x_fine (req_chan.start_x_fine),
      .start_y_fine (req_chan.start_y_fine),
      .stop_x_fine  (req_chan.stop_x_fine),
      .stop_y_fine  (req_chan.stop_y_fine),
      .sts          (sts),
      .cand_valid   (cand_valid),
      .cand_x       (cand_x),
      .cand_y       (cand_y)
   );

   rct_emit #(
      .CELL_W (CELL_W)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cand_valid (cand_valid),
      .cand_x     (cand_x),
      .cand_y     (cand_y),
      .stall      (stall),
      .rsp        (rsp_chan)
   );
endmodule
